### design/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the aging priority scheduler
// Holds the slot table size, the request and result structs, and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package aps_pkg;

	// Slot table size and derived index width
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Field widths fixed by the interface
	localparam int FIELD_SLOT_W = 4;
	localparam int PRIO_W       = 8;
	localparam int LEN_W        = 8;
	localparam int TICK_W       = 16;

	// Request modes
	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [FIELD_SLOT_W-1:0]  slot;
		logic signed [PRIO_W-1:0] start_priority;
		logic [LEN_W-1:0]         service_length;
	} aps_req_t;

	typedef struct packed {
		logic                    grant_valid;
		logic [FIELD_SLOT_W-1:0] grant_slot;
		logic                    first_run;
		logic                    retire_valid;
		logic [FIELD_SLOT_W-1:0] retire_slot;
		logic [TICK_W-1:0]       tick_time;
	} aps_rsp_t;

	// Tick sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RETIRE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_AGE    = 5'b01000,
		ST_DONE   = 5'b10000
	} aps_state_t;

endpackage

### design/aps_prio_unit.sv
// ----------------------------------------------------------------------------
// aps_prio_unit: shared priority compare and saturating step
// Compares one slot priority against the running best, and produces the
// priority stepped by one in either direction, clamped to the 8-bit range.
// ----------------------------------------------------------------------------
module aps_prio_unit
	import aps_pkg::*;
(
	input  logic signed [PRIO_W-1:0] prio,
	input  logic signed [PRIO_W-1:0] best,
	input  logic                     step_down,
	output logic                     greater,
	output logic signed [PRIO_W-1:0] stepped
);

	logic signed [PRIO_W:0] sum;

	// Compare against the running best
	assign greater = (prio > best);

	// Step by one and clamp at the signed limits
	always_comb begin
		if (step_down) begin
			sum = {prio[PRIO_W-1], prio} - (PRIO_W+1)'(1);
		end else begin
			sum = {prio[PRIO_W-1], prio} + (PRIO_W+1)'(1);
		end
		if (sum[PRIO_W] != sum[PRIO_W-1]) begin
			stepped = sum[PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}} : {1'b0, {(PRIO_W-1){1'b1}}};
		end else begin
			stepped = sum[PRIO_W-1:0];
		end
	end

endmodule

### design/aging_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// aging_priority_scheduler_top: dynamic priority scheduler with aging
// Arrivals load a free job slot; each tick retires the finished job,
// grants the highest-priority ready slot, and ages the slot table.
// ----------------------------------------------------------------------------
// An arrival request (mode 0) is absorbed in the cycle it is accepted and
// gives no result; busy stays low. A tick request (mode 1) steps through
// the sequencer states in order: ST_RETIRE checks the running job for
// retirement, ST_SCAN walks all NUM_SLOTS slots through the shared priority
// comparator, ST_AGE steps each ready slot through the same saturating step
// unit (skipped when no slot is ready), and ST_DONE registers the result.
// The result is shown on rsp for one cycle with done high, and the receiver
// cannot stall it. busy is high from the cycle after a tick is accepted
// until the result cycle.
module aging_priority_scheduler_top
	import aps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  aps_req_t req,
	output logic     done,
	output aps_rsp_t rsp
);

	// Slot table
	logic                     ready_q [NUM_SLOTS];
	logic signed [PRIO_W-1:0] prio_q  [NUM_SLOTS];
	logic [LEN_W-1:0]         runs_q  [NUM_SLOTS];
	logic [LEN_W-1:0]         len_q   [NUM_SLOTS];

	aps_state_t               state_q;
	logic [SLOT_W-1:0]        idx_q;
	logic                     cur_valid_q;
	logic [SLOT_W-1:0]        cur_slot_q;
	logic [TICK_W-1:0]        tick_q;
	logic                     found_q;
	logic signed [PRIO_W-1:0] best_q;
	logic [SLOT_W-1:0]        gslot_q;
	logic                     first_q;
	logic                     retire_q;
	logic [SLOT_W-1:0]        rslot_q;
	logic                     done_q;
	aps_rsp_t                 rsp_q;

	logic                     accept;
	logic [SLOT_W-1:0]        arr_idx;
	logic                     arr_ok;
	logic                     last_idx;
	logic                     greater;
	logic signed [PRIO_W-1:0] stepped;
	logic                     is_gslot;

	assign accept   = start && !busy;
	assign arr_idx  = SLOT_W'(req.slot);
	assign arr_ok   = (int'(req.slot) < NUM_SLOTS) && !ready_q[arr_idx];
	assign last_idx = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign is_gslot = (idx_q == gslot_q);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Shared compare and saturating step unit, addressed by the scan index
	aps_prio_unit u_prio (
		.prio      (prio_q[idx_q]),
		.best      (best_q),
		.step_down (is_gslot),
		.greater   (greater),
		.stepped   (stepped)
	);

	// Sequence the tick: retire check, scan, age, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			tick_q      <= '0;
			found_q     <= 1'b0;
			retire_q    <= 1'b0;
			done_q      <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ready_q[i] <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.mode == MODE_ARRIVAL && arr_ok) begin
						ready_q[arr_idx] <= 1'b1;
					end
					if (accept && req.mode == MODE_TICK) begin
						idx_q    <= cur_slot_q;
						found_q  <= 1'b0;
						retire_q <= 1'b0;
						state_q  <= ST_RETIRE;
					end
				end
				ST_RETIRE: begin
					if (cur_valid_q && runs_q[idx_q] == len_q[idx_q]) begin
						ready_q[idx_q] <= 1'b0;
						retire_q       <= 1'b1;
					end
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (ready_q[idx_q] && (!found_q || greater)) begin
						found_q <= 1'b1;
					end
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= (found_q || ready_q[idx_q]) ? ST_AGE : ST_DONE;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_AGE: begin
					if (last_idx) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_DONE: begin
					cur_valid_q <= found_q;
					if (found_q) begin
						cur_slot_q <= gslot_q;
					end
					tick_q  <= tick_q + TICK_W'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot payload: load on arrival, age during the tick
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && req.mode == MODE_ARRIVAL && arr_ok) begin
			prio_q[arr_idx] <= req.start_priority;
			runs_q[arr_idx] <= '0;
			len_q[arr_idx]  <= req.service_length;
		end
		if (state_q == ST_AGE && ready_q[idx_q]) begin
			prio_q[idx_q] <= stepped;
			if (is_gslot) begin
				runs_q[idx_q] <= runs_q[idx_q] + LEN_W'(1);
			end
		end
	end

	// Track the best candidate during the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_RETIRE) begin
			rslot_q <= idx_q;
		end
		if (state_q == ST_SCAN && ready_q[idx_q] && (!found_q || greater)) begin
			best_q  <= prio_q[idx_q];
			gslot_q <= idx_q;
			first_q <= (runs_q[idx_q] == '0);
		end
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			rsp_q.grant_valid  <= found_q;
			rsp_q.grant_slot   <= found_q ? FIELD_SLOT_W'(gslot_q) : '0;
			rsp_q.first_run    <= found_q && first_q;
			rsp_q.retire_valid <= retire_q;
			rsp_q.retire_slot  <= retire_q ? FIELD_SLOT_W'(rslot_q) : '0;
			rsp_q.tick_time    <= tick_q;
		end
	end

	// A result appears only right after the report cycle, with the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(state_q == ST_DONE)))
		else $error("result strobe outside report cycle");

	// An accepted tick makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_TICK) |=> busy)
		else $error("tick accepted but block not busy");

	// A granted job becomes the running job
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.grant_valid) |-> (cur_valid_q && FIELD_SLOT_W'(cur_slot_q) == rsp.grant_slot))
		else $error("grant not recorded as running job");

	// A retired slot is no longer ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.retire_valid && !rsp.grant_valid) |-> !ready_q[rslot_q])
		else $error("retired slot still ready");

endmodule

### tb/sv/tb_aging_priority_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_priority_scheduler_top: self-checking bench for the aging scheduler
// Drives arrival and tick requests through the start/busy handshake with
// random idle gaps, predicts every tick result from a software copy of the
// slot table, and checks each done strobe field by field.
// ----------------------------------------------------------------------------
module tb_aging_priority_scheduler_top;
	import aps_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int TICK_CYCLES  = 2 * NUM_SLOTS + 3;
	localparam int PRIO_MAX     = (1 << (PRIO_W - 1)) - 1;
	localparam int PRIO_MIN     = -(1 << (PRIO_W - 1));
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_LIMIT  = 1500;
	localparam int IDLE_PCT     = 24;

	// Slot table copy, predicted tick results and mismatch count
	class sched_scoreboard;
		bit                       ready [NUM_SLOTS];
		logic signed [PRIO_W-1:0] prio [NUM_SLOTS];
		logic [LEN_W-1:0]         runs [NUM_SLOTS];
		logic [LEN_W-1:0]         length [NUM_SLOTS];
		bit                       run_valid;
		int                       run_slot;
		logic [TICK_W-1:0]        tick_ctr;
		aps_rsp_t                 expected_ticks [$];
		int                       errors;

		function new();
			foreach (ready[i]) begin
				ready[i]  = 1'b0;
				prio[i]   = '0;
				runs[i]   = '0;
				length[i] = '0;
			end
			run_valid = 1'b0;
			run_slot  = 0;
			tick_ctr  = '0;
			errors    = 0;
		endfunction

		function bit slot_free(logic [FIELD_SLOT_W-1:0] s);
			return int'(s) < NUM_SLOTS && !ready[s];
		endfunction

		function int occupancy();
			int n;
			n = 0;
			foreach (ready[i])
				if (ready[i])
					n++;
			return n;
		endfunction

		function int outstanding();
			return expected_ticks.size();
		endfunction

		// Retire, grant, then age the table for one tick
		function aps_rsp_t predict_tick();
			aps_rsp_t e;
			int       best;
			int       win;
			int       v;
			bit       found;
			e     = '0;
			found = 1'b0;
			best  = 0;
			win   = 0;
			// retire the running job once it has all its runs
			if (run_valid && runs[run_slot] == length[run_slot]) begin
				e.retire_valid = 1'b1;
				e.retire_slot  = FIELD_SLOT_W'(run_slot);
				ready[run_slot] = 1'b0;
				run_valid       = 1'b0;
			end
			// pick the highest priority, lowest slot on ties
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (ready[i] && (!found || int'(prio[i]) > best)) begin
					found = 1'b1;
					best  = int'(prio[i]);
					win   = i;
				end
			end
			if (found) begin
				e.grant_valid = 1'b1;
				e.grant_slot  = FIELD_SLOT_W'(win);
				e.first_run   = (runs[win] == '0);
				runs[win]     = runs[win] + 1'b1;
				// age with saturation: winner drops, the rest rise
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (ready[i]) begin
						v = int'(prio[i]) + ((i == win) ? -1 : 1);
						if (v > PRIO_MAX)
							v = PRIO_MAX;
						if (v < PRIO_MIN)
							v = PRIO_MIN;
						prio[i] = v[PRIO_W-1:0];
					end
				end
				run_valid = 1'b1;
				run_slot  = win;
			end else begin
				run_valid = 1'b0;
			end
			e.tick_time = tick_ctr;
			tick_ctr    = tick_ctr + 1'b1;
			return e;
		endfunction

		function void note_request(aps_req_t r);
			if (r.mode == MODE_ARRIVAL) begin
				// load only a free slot; occupied slots drop the request
				if (slot_free(r.slot)) begin
					ready[r.slot]  = 1'b1;
					prio[r.slot]   = r.start_priority;
					runs[r.slot]   = '0;
					length[r.slot] = r.service_length;
				end
			end else begin
				expected_ticks.insert(expected_ticks.size(), predict_tick());
			end
		endfunction

		function void compare_field(string name, logic [TICK_W-1:0] want,
				logic [TICK_W-1:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_tick(aps_rsp_t got);
			aps_rsp_t e;
			if (expected_ticks.size() == 0) begin
				$error("tick result with no request pending, tick_time %0d", got.tick_time);
				errors++;
				return;
			end
			e = expected_ticks.pop_front();
			compare_field("grant_valid", TICK_W'(e.grant_valid), TICK_W'(got.grant_valid));
			compare_field("grant_slot", TICK_W'(e.grant_slot), TICK_W'(got.grant_slot));
			compare_field("first_run", TICK_W'(e.first_run), TICK_W'(got.first_run));
			compare_field("retire_valid", TICK_W'(e.retire_valid),
				TICK_W'(got.retire_valid));
			compare_field("retire_slot", TICK_W'(e.retire_slot), TICK_W'(got.retire_slot));
			compare_field("tick_time", e.tick_time, got.tick_time);
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	aps_req_t req;
	aps_rsp_t rsp;
	bit       steady_drive;

	sched_scoreboard board = new();

	aging_priority_scheduler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Random request; mostly short jobs so the table keeps turning over
	function automatic aps_req_t random_request();
		aps_req_t r;
		int       pick;
		r.mode           = ($urandom_range(0, 99) < 50) ? MODE_TICK : MODE_ARRIVAL;
		r.slot           = FIELD_SLOT_W'($urandom_range(0, (1 << FIELD_SLOT_W) - 1));
		r.start_priority = PRIO_W'($urandom);
		pick             = $urandom_range(0, 99);
		if (pick < 70)
			r.service_length = LEN_W'($urandom_range(1, 6));
		else if (pick < 97)
			r.service_length = LEN_W'($urandom_range(7, 40));
		else
			r.service_length = LEN_W'($urandom);
		return r;
	endfunction

	// Hold start through busy, then record the accepted request
	task automatic send_request(input aps_req_t r);
		while (!steady_drive && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			start <= 1'b0;
			req   <= random_request();
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(r);
	endtask

	task automatic send_tick();
		aps_req_t r;
		r      = random_request();
		r.mode = MODE_TICK;
		send_request(r);
	endtask

	task automatic send_arrival(input int s, input int p, input int len);
		aps_req_t r;
		r                = '0;
		r.mode           = MODE_ARRIVAL;
		r.slot           = FIELD_SLOT_W'(s);
		r.start_priority = PRIO_W'(p);
		r.service_length = LEN_W'(len);
		send_request(r);
	endtask

	// Tick until every job has retired, with a cap for jobs that never end
	task automatic drain_table();
		int n;
		n = 0;
		while (board.occupancy() > 0 && n < DRAIN_LIMIT) begin
			send_tick();
			n++;
		end
	endtask

	// Collect results on every done strobe
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && done)
				board.check_tick(rsp);
		end
	end

	// Stimulus
	initial begin
		int       counted;
		aps_req_t r;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		steady_drive = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, lowest priority pinned at the floor, occupied slot
		send_tick();
		send_arrival(0, PRIO_MIN, 1);
		send_arrival(0, PRIO_MAX, 5);
		send_tick();
		send_tick();
		// ties at the ceiling, saturating rise, mixed extremes
		send_arrival(15, PRIO_MAX, 2);
		send_arrival(7, PRIO_MAX, 3);
		send_arrival(3, PRIO_MAX - 1, 1);
		send_arrival(12, PRIO_MIN, 4);
		drain_table();

		// random traffic; one window runs gap-free
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r            = random_request();
			steady_drive = (counted >= 150 && counted < 250);
			counted++;
			send_request(r);
		end
		steady_drive = 1'b0;
		drain_table();

		// zero-length job: its run count wraps, so it retires after 256 runs
		send_arrival(2, 0, 0);
		repeat (3) send_tick();
		send_arrival(9, -3, 3);
		drain_table();

		@(negedge clk);
		start <= 1'b0;
		while (board.outstanding() > 0)
			@(posedge clk);
		repeat (TICK_CYCLES + 5) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
